[rtl/lir_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_pkg
// shared constants, codes and structs of the linear interpolation resampler
// ----------------------------------------------------------------------------
package lir_pkg;

	// field and register widths
	localparam int SAMPLE_BITS       = 24;
	localparam int RATIO_FRAC_BITS   = 16;
	localparam int RATIO_BITS        = 20;
	localparam int MAX_INPUT_SAMPLES = 1024;
	localparam int ADDR_BITS         = $clog2(MAX_INPUT_SAMPLES);
	localparam int INLEN_BITS        = 11;
	localparam int OUTLEN_BITS       = 16;
	localparam int INDEX_BITS        = 16;
	localparam int CFG_INDEX_BITS    = 2;
	localparam int CFG_DATA_BITS     = 20;

	// datapath widths
	localparam int POS_BITS  = INDEX_BITS + RATIO_BITS;
	localparam int F_BITS    = POS_BITS - RATIO_FRAC_BITS;
	localparam int T_BITS    = RATIO_FRAC_BITS;
	localparam int DIFF_BITS = SAMPLE_BITS + 1;
	localparam int PROD_BITS = DIFF_BITS + T_BITS + 1;
	localparam int ACC_BITS  = PROD_BITS + 1;
	localparam int MAG_BITS  = SAMPLE_BITS + RATIO_FRAC_BITS;
	localparam int HALF_BITS = MAG_BITS / 2;
	localparam int PP_BITS   = HALF_BITS + RATIO_BITS;
	localparam int FULL_BITS = MAG_BITS + RATIO_BITS;
	localparam int Q_BITS    = FULL_BITS - 2 * RATIO_FRAC_BITS;

	// saturation limits on the magnitude
	localparam logic [Q_BITS-1:0] LIM_POS = Q_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic [Q_BITS-1:0] LIM_NEG = Q_BITS'(64'd1 << (SAMPLE_BITS - 1));

	// register reset values
	localparam logic [RATIO_BITS-1:0]  RATIO_RESET      = RATIO_BITS'(65536);
	localparam logic [INLEN_BITS-1:0]  IN_LENGTH_RESET  = INLEN_BITS'(1024);
	localparam logic [OUTLEN_BITS-1:0] OUT_LENGTH_RESET = OUTLEN_BITS'(1024);

	typedef enum logic [0:0] {
		CMD_WRITE = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_RATIO      = 2'd0,
		REG_IN_LENGTH  = 2'd1,
		REG_OUT_LENGTH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [RATIO_BITS-1:0]  ratio;
		logic [INLEN_BITS-1:0]  in_length;
		logic [OUTLEN_BITS-1:0] out_length;
	} cfg_t;

	// read item leaving the address stage
	typedef struct packed {
		logic              valid;
		logic              oor;
		logic              pe;
		logic [T_BITS-1:0] t;
	} rd_item_t;

	// per-stage control of the arithmetic pipeline
	typedef struct packed {
		logic valid;
		logic oor;
		logic pe;
	} ctl_t;

	// sample buffer access
	typedef struct packed {
		logic                   we;
		logic [ADDR_BITS-1:0]   waddr;
		logic [SAMPLE_BITS-1:0] wdata;
		logic                   re;
		logic [ADDR_BITS-1:0]   raddr0;
		logic [ADDR_BITS-1:0]   raddr1;
	} ram_req_t;

endpackage

[rtl/lir_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_req_if
// request channel: sample writes and output sample reads
// ----------------------------------------------------------------------------
interface lir_req_if import lir_pkg::*; ();

	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [ADDR_BITS-1:0]          sample_address;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic [INDEX_BITS-1:0]         output_index;

	modport source (
		output valid, command, sample_address, sample_value, output_index,
		input  ready
	);

	modport sink (
		input  valid, command, sample_address, sample_value, output_index,
		output ready
	);

endinterface

[rtl/lir_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_rsp_if
// response channel: interpolated output samples with status flags
// ----------------------------------------------------------------------------
interface lir_rsp_if import lir_pkg::*; ();

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_sample;
	logic                          past_input_end;
	logic                          index_out_of_range;
	logic                          saturated;

	modport source (
		output valid, out_sample, past_input_end, index_out_of_range, saturated,
		input  ready
	);

	modport sink (
		input  valid, out_sample, past_input_end, index_out_of_range, saturated,
		output ready
	);

endinterface

[rtl/linear_interp_resampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_resampler
// fixed-ratio linear interpolation resampler over a sample buffer
// ----------------------------------------------------------------------------
//
// channel   direction  handshake      payload
// req       sink       valid/ready    command, sample_address, sample_value,
//                                     output_index
// rsp       source     valid/ready    out_sample, past_input_end,
//                                     index_out_of_range, saturated
// cfg       sink       cfg_we only    cfg_index, cfg_data
//
// one transfer per cycle sustained while the response side is ready; a read passes
// seven register stages: the position multiply, the 1024x24 two-read-port buffer
// ram, difference, interpolation multiply, absolute value, gain partial products
// and the saturating output register
// reset clears control state only; the sample buffer holds garbage until written
// each stage holds while it is full and its successor holds, empty stages fill up behind a
// stalled output register
// ----------------------------------------------------------------------------
module linear_interp_resampler import lir_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	lir_req_if.sink                   req,
	lir_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cfg_t                   cfg_q;
	rd_item_t               item;
	ram_req_t               ram_req;
	logic                   s2_ready;
	logic [SAMPLE_BITS-1:0] x0_raw;
	logic [SAMPLE_BITS-1:0] x1_raw;

	// configuration registers, writes to an unused index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ratio      <= RATIO_RESET;
			cfg_q.in_length  <= IN_LENGTH_RESET;
			cfg_q.out_length <= OUT_LENGTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RATIO: begin
					cfg_q.ratio <= cfg_data[RATIO_BITS-1:0];
				end
				REG_IN_LENGTH: begin
					cfg_q.in_length <= cfg_data[INLEN_BITS-1:0];
				end
				REG_OUT_LENGTH: begin
					cfg_q.out_length <= cfg_data[OUTLEN_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// stage 1: position, range checks, buffer addresses and sample writes
	lir_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg_q),
		.s2_ready (s2_ready),
		.item     (item),
		.ram_req  (ram_req)
	);

	// sample buffer, both neighbors read in the same cycle
	lir_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_INPUT_SAMPLES)
	) u_buf (
		.clk     (clk),
		.we      (ram_req.we),
		.waddr   (ram_req.waddr),
		.wdata   (ram_req.wdata),
		.re      (ram_req.re),
		.raddr_a (ram_req.raddr0),
		.raddr_b (ram_req.raddr1),
		.rdata_a (x0_raw),
		.rdata_b (x1_raw)
	);

	// stages 2 to 6 and the output register
	lir_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.s2_ready (s2_ready),
		.x0       (x0_raw),
		.x1       (x1_raw),
		.ratio    (cfg_q.ratio),
		.rsp      (rsp)
	);

`ifndef NO_ASSERTIONS
	// an accepted read shows up as a read item in stage 1, a write does not
	a_read_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (item.valid == $past(req.command == CMD_READ)))
		else $error("stage 1 read item does not match accepted command");

	// out-of-range reads return a clean zero
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.index_out_of_range) |->
		(rsp.out_sample == '0 && !rsp.past_input_end && !rsp.saturated))
		else $error("out-of-range read returned data or extra flags");

	// a clipped result sits on one of the two limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.saturated) |->
		(rsp.out_sample == SAMPLE_BITS'(LIM_POS) || rsp.out_sample == SAMPLE_BITS'(LIM_NEG)))
		else $error("saturated result not at a limit");

	// a sample write leaves stage 1 without a read item beside it
	a_write_alone: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> !item.valid)
		else $error("buffer write together with a read item");
`endif

endmodule

[rtl/lir_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module lir_ram import lir_pkg::*; #(
	parameter int WIDTH = SAMPLE_BITS,
	parameter int DEPTH = MAX_INPUT_SAMPLES
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

[rtl/lir_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_front
// request stage: position multiply, range checks and buffer addressing
// ----------------------------------------------------------------------------
module lir_front import lir_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lir_req_if.sink   req,
	input  cfg_t      cfg,
	input  logic      s2_ready,
	output rd_item_t  item,
	output ram_req_t  ram_req
);

	logic                   v_s1;
	logic                   cmd_s1;
	logic [ADDR_BITS-1:0]   addr_s1;
	logic [SAMPLE_BITS-1:0] value_s1;
	logic                   oor_s1;
	logic [POS_BITS-1:0]    pos_s1;

	logic                   s1_ready;
	logic [POS_BITS-1:0]    pos_next;
	logic [F_BITS-1:0]      f;
	logic [INLEN_BITS-1:0]  len_eff;
	logic                   pe;

	assign s1_ready  = !v_s1 || s2_ready;
	assign req.ready = s1_ready;
	assign pos_next  = POS_BITS'(req.output_index) * POS_BITS'(cfg.ratio);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && req.valid) begin
			cmd_s1   <= req.command;
			addr_s1  <= req.sample_address;
			value_s1 <= req.sample_value;
			oor_s1   <= req.output_index >= cfg.out_length;
			pos_s1   <= pos_next;
		end
	end

	// integer part selects the sample pair, lengths above the buffer clamp
	assign f       = pos_s1[POS_BITS-1:RATIO_FRAC_BITS];
	assign len_eff = (cfg.in_length > INLEN_BITS'(MAX_INPUT_SAMPLES)) ?
		INLEN_BITS'(MAX_INPUT_SAMPLES) : cfg.in_length;
	assign pe      = ((F_BITS + 1)'(f) + (F_BITS + 1)'(1)) >= (F_BITS + 1)'(len_eff);

	always_comb begin
		item.valid = v_s1 && (cmd_s1 == CMD_READ);
		item.oor   = oor_s1;
		item.pe    = pe && !oor_s1;
		item.t     = pos_s1[T_BITS-1:0];

		ram_req.we     = v_s1 && (cmd_s1 == CMD_WRITE) && s2_ready;
		ram_req.waddr  = addr_s1;
		ram_req.wdata  = value_s1;
		ram_req.re     = s2_ready;
		ram_req.raddr0 = f[ADDR_BITS-1:0];
		ram_req.raddr1 = f[ADDR_BITS-1:0] + ADDR_BITS'(1);
	end

endmodule

[rtl/lir_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lir_datapath
// interpolation, gain, saturation and the output register
// ----------------------------------------------------------------------------
module lir_datapath import lir_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rd_item_t                      item,
	output logic                          s2_ready,
	input  logic signed [SAMPLE_BITS-1:0] x0,
	input  logic signed [SAMPLE_BITS-1:0] x1,
	input  logic [RATIO_BITS-1:0]         ratio,
	lir_rsp_if.source                     rsp
);

	ctl_t ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic rdy3, rdy4, rdy5, rdy6, out_ready;

	logic [T_BITS-1:0]             t_s2, t_s3;
	logic signed [DIFF_BITS-1:0]   diff_s3;
	logic signed [SAMPLE_BITS-1:0] x0_s3, x0_s4;
	logic signed [PROD_BITS-1:0]   prod_s4;
	logic [MAG_BITS-1:0]           mag_s5;
	logic                          neg_s5, neg_s6;
	logic [PP_BITS-1:0]            plo_s6, phi_s6;

	logic                          out_v_q;
	logic [SAMPLE_BITS-1:0]        out_sample_q;
	logic                          pe_q, oor_q, sat_q;

	logic signed [DIFF_BITS-1:0]   diff;
	logic signed [PROD_BITS-1:0]   prod;
	logic signed [ACC_BITS-1:0]    acc;
	logic [ACC_BITS-1:0]           acc_abs;
	logic [FULL_BITS-1:0]          full;
	logic [Q_BITS-1:0]             q, q_lim, q_res;
	logic                          sat;

	// a stage moves when it is empty or its successor moves
	assign out_ready = !out_v_q || rsp.ready;
	assign rdy6      = !ctl_s6.valid || out_ready;
	assign rdy5      = !ctl_s5.valid || rdy6;
	assign rdy4      = !ctl_s4.valid || rdy5;
	assign rdy3      = !ctl_s3.valid || rdy4;
	assign s2_ready  = !ctl_s2.valid || rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2  <= '0;
			ctl_s3  <= '0;
			ctl_s4  <= '0;
			ctl_s5  <= '0;
			ctl_s6  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (s2_ready) begin
				ctl_s2 <= '{valid: item.valid, oor: item.oor, pe: item.pe};
			end
			if (rdy3) begin
				ctl_s3 <= ctl_s2;
			end
			if (rdy4) begin
				ctl_s4 <= ctl_s3;
			end
			if (rdy5) begin
				ctl_s5 <= ctl_s4;
			end
			if (rdy6) begin
				ctl_s6 <= ctl_s5;
			end
			if (out_ready) begin
				out_v_q <= ctl_s6.valid;
			end
		end
	end

	// x0*(1-t) + x1*t rewritten as x0*one + (x1-x0)*t
	assign diff = $signed({x1[SAMPLE_BITS-1], x1}) - $signed({x0[SAMPLE_BITS-1], x0});
	assign prod = diff_s3 * $signed({1'b0, t_s3});
	assign acc  = $signed({{(ACC_BITS - SAMPLE_BITS - RATIO_FRAC_BITS){x0_s4[SAMPLE_BITS-1]}},
		x0_s4, {RATIO_FRAC_BITS{1'b0}}}) + ACC_BITS'(prod_s4);
	assign acc_abs = acc[ACC_BITS-1] ? (ACC_BITS'(0) - acc) : acc;

	// gain product from two partial products, then drop the two fractions
	assign full  = (FULL_BITS'(phi_s6) << HALF_BITS) + FULL_BITS'(plo_s6);
	assign q     = full[FULL_BITS-1:2*RATIO_FRAC_BITS];
	assign sat   = neg_s6 ? (q > LIM_NEG) : (q > LIM_POS);
	assign q_lim = sat ? (neg_s6 ? LIM_NEG : LIM_POS) : q;
	assign q_res = neg_s6 ? (Q_BITS'(0) - q_lim) : q_lim;

	always_ff @(posedge clk) begin
		if (s2_ready) begin
			t_s2 <= item.t;
		end
		if (rdy3) begin
			diff_s3 <= diff;
			x0_s3   <= x0;
			t_s3    <= t_s2;
		end
		if (rdy4) begin
			prod_s4 <= prod;
			x0_s4   <= x0_s3;
		end
		if (rdy5) begin
			mag_s5 <= acc_abs[MAG_BITS-1:0];
			neg_s5 <= acc[ACC_BITS-1];
		end
		if (rdy6) begin
			plo_s6 <= PP_BITS'(mag_s5[HALF_BITS-1:0]) * PP_BITS'(ratio);
			phi_s6 <= PP_BITS'(mag_s5[MAG_BITS-1:HALF_BITS]) * PP_BITS'(ratio);
			neg_s6 <= neg_s5;
		end
		if (out_ready) begin
			// flagged reads return zero with no saturation
			if (ctl_s6.oor || ctl_s6.pe) begin
				out_sample_q <= '0;
				sat_q        <= 1'b0;
			end else begin
				out_sample_q <= q_res[SAMPLE_BITS-1:0];
				sat_q        <= sat;
			end
			pe_q  <= ctl_s6.pe;
			oor_q <= ctl_s6.oor;
		end
	end

	assign rsp.valid              = out_v_q;
	assign rsp.out_sample         = out_sample_q;
	assign rsp.past_input_end     = pe_q;
	assign rsp.index_out_of_range = oor_q;
	assign rsp.saturated          = sat_q;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for linear_interp_resampler: sample writes and output
// reads are sent over the request channel, each read is predicted from a
// local copy of the buffer and registers, and every response transfer is
// compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module testbench import lir_pkg::*; ();

	// result fields of one read, in the order the response channel carries them
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_sample;
		logic                          past_input_end;
		logic                          index_out_of_range;
		logic                          saturated;
	} rsp_fields_t;

	// pipeline is 7 deep, leave some margin before touching registers
	localparam int SETTLE_CYCLES = 12;
	// cycles without any transfer before the run is declared hung
	localparam int STALL_LIMIT   = 3000;
	// long receiver hold-off used to back the pipeline up into the request side
	localparam int HOLD_CYCLES   = 300;
	// register index past the end of the map, writes to it must be dropped
	localparam logic [CFG_INDEX_BITS-1:0] REG_NONE = 2'd3;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	lir_req_if req_ch ();
	lir_rsp_if rsp_ch ();

	linear_interp_resampler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// local copy of the block state
	logic signed [SAMPLE_BITS-1:0] sample_buf [MAX_INPUT_SAMPLES];
	logic [RATIO_BITS-1:0]         gain_ratio;
	logic [INLEN_BITS-1:0]         input_len;
	logic [OUTLEN_BITS-1:0]        output_len;

	// predicted outputs of accepted reads, oldest first
	rsp_fields_t pending_outputs [$];

	int errors        = 0;
	bit gaps_on       = 1'b0;   // random idling on both channels
	int hold_request  = 0;      // long receiver hold-off, picked up by the ready process

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// output sample for index idx: position idx*ratio in Q.16, linear blend of
	// the two neighbors, gain by ratio, truncate toward zero, clip to 24 bits
	function automatic rsp_fields_t resample_point(input logic [INDEX_BITS-1:0] idx);
		rsp_fields_t       r;
		int unsigned       span;
		logic [POS_BITS-1:0] pos;
		int unsigned       f;
		longint            w;
		longint            x0;
		longint            x1;
		longint            acc;
		longint unsigned   mag;
		longint unsigned   g;
		longint unsigned   q;
		longint unsigned   lim_pos;
		longint unsigned   lim_neg;
		logic              neg;
		r = '0;
		// index check wins over the input-end check
		if (idx >= output_len) begin
			r.index_out_of_range = 1'b1;
			return r;
		end
		// lengths past the buffer size count as the buffer size
		span = (input_len > MAX_INPUT_SAMPLES) ? MAX_INPUT_SAMPLES : input_len;
		pos  = POS_BITS'(idx) * POS_BITS'(gain_ratio);
		f    = pos[POS_BITS-1:RATIO_FRAC_BITS];
		w    = pos[RATIO_FRAC_BITS-1:0];
		if (f + 1 >= span) begin
			r.past_input_end = 1'b1;
			return r;
		end
		x0  = sample_buf[f];
		x1  = sample_buf[f + 1];
		acc = x0 * ((longint'(1) << RATIO_FRAC_BITS) - w) + x1 * w;
		// work on the magnitude so the shift truncates toward zero
		neg = (acc < 0);
		mag = neg ? -acc : acc;
		g   = gain_ratio;
		q   = (mag * g) >> (2 * RATIO_FRAC_BITS);
		lim_pos = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
		lim_neg = 64'd1 << (SAMPLE_BITS - 1);
		if (!neg && q > lim_pos) begin
			q = lim_pos;
			r.saturated = 1'b1;
		end
		if (neg && q > lim_neg) begin
			q = lim_neg;
			r.saturated = 1'b1;
		end
		if (neg) begin
			q = 64'd0 - q;
		end
		r.out_sample = SAMPLE_BITS'(q);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// random picks
	// ------------------------------------------------------------------

	// mostly back to back, sometimes a short gap, now and then a long one
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SAMPLE_BITS'($signed($urandom_range(0, 511)) - 256);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// indices mostly land inside the input span so the blend path is exercised,
	// with some spread past the span and past out_length
	function automatic logic [INDEX_BITS-1:0] pick_index();
		int unsigned span;
		int unsigned reach;
		if ($urandom_range(0, 99) < 15) begin
			return INDEX_BITS'($urandom);
		end
		span  = (input_len > MAX_INPUT_SAMPLES) ? MAX_INPUT_SAMPLES : input_len;
		reach = (gain_ratio == 0) ? 65535 : ((span + 1) << RATIO_FRAC_BITS) / gain_ratio;
		if (reach > output_len + 2) begin
			reach = output_len + 2;
		end
		if (reach > 65535) begin
			reach = 65535;
		end
		return INDEX_BITS'($urandom_range(0, reach));
	endfunction

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------

	// offer one item and hold it until the transfer, then update the local state
	task automatic send_item(input cmd_t cmd, input logic [ADDR_BITS-1:0] addr,
			input logic signed [SAMPLE_BITS-1:0] value, input logic [INDEX_BITS-1:0] idx);
		int gap;
		req_ch.valid          <= 1'b1;
		req_ch.command        <= cmd;
		req_ch.sample_address <= addr;
		req_ch.sample_value   <= value;
		req_ch.output_index   <= idx;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (cmd == CMD_WRITE) begin
			sample_buf[addr] = value;
		end else begin
			pending_outputs.insert(pending_outputs.size(), resample_point(idx));
		end
		gap = gaps_on ? gap_length() : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// unused payload fields carry random bits so every input bit toggles
	task automatic write_sample(input logic [ADDR_BITS-1:0] addr,
			input logic signed [SAMPLE_BITS-1:0] value);
		send_item(CMD_WRITE, addr, value, INDEX_BITS'($urandom));
	endtask

	task automatic read_output(input logic [INDEX_BITS-1:0] idx);
		send_item(CMD_READ, ADDR_BITS'($urandom), SAMPLE_BITS'($urandom), idx);
	endtask

	// stop offering and wait until every predicted output has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
	endtask

	// writes may still be in the pipe after the last read result
	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_RATIO:      gain_ratio = data[RATIO_BITS-1:0];
			REG_IN_LENGTH:  input_len  = data[INLEN_BITS-1:0];
			REG_OUT_LENGTH: output_len = data[OUTLEN_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// response side
	// ------------------------------------------------------------------

	// receiver readiness: random stalls while gaps are on, plus the long
	// hold-off when a test asks for one
	initial begin : rsp_ready_gen
		int stall_left;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (hold_request > 0) begin
					stall_left   = hold_request;
					hold_request = 0;
				end
				if (stall_left > 0) begin
					rsp_ch.ready <= 1'b0;
					stall_left--;
				end else begin
					rsp_ch.ready <= 1'b1;
					if (gaps_on) begin
						stall_left = gap_length();
					end
				end
			end
		end
	end

	// every response transfer is matched against the oldest prediction
	always @(posedge clk) begin : output_check
		rsp_fields_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_outputs.size() == 0) begin
				$error("output transfer with nothing outstanding: out_sample %0d",
					rsp_ch.out_sample);
				errors++;
			end else begin
				want = pending_outputs.pop_front();
				if (rsp_ch.out_sample !== want.out_sample) begin
					$error("out_sample expected %0d got %0d", want.out_sample,
						rsp_ch.out_sample);
					errors++;
				end
				if (rsp_ch.past_input_end !== want.past_input_end) begin
					$error("past_input_end expected %0b got %0b", want.past_input_end,
						rsp_ch.past_input_end);
					errors++;
				end
				if (rsp_ch.index_out_of_range !== want.index_out_of_range) begin
					$error("index_out_of_range expected %0b got %0b",
						want.index_out_of_range, rsp_ch.index_out_of_range);
					errors++;
				end
				if (rsp_ch.saturated !== want.saturated) begin
					$error("saturated expected %0b got %0b", want.saturated,
						rsp_ch.saturated);
					errors++;
				end
			end
		end
	end

	// hang detection: counts cycles with no transfer on either channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("linear_interp_resampler test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset registers: unity ratio, full buffer, 1024 outputs
	task automatic test_reset_defaults();
		gaps_on = 1'b0;
		write_sample(0, SAMPLE_MAX);
		write_sample(1, SAMPLE_MIN);
		write_sample(2, -1);
		write_sample(3, 0);
		write_sample(1022, 1);
		write_sample(1023, SAMPLE_BITS'(24'h5a5a5a));
		read_output(0);         // full positive sample through unity gain
		read_output(1);         // full negative sample
		read_output(2);         // minus one survives the gain
		read_output(1022);      // last pair inside the buffer
		read_output(1023);      // neighbor would be past the input end
		read_output(1024);      // first index past out_length
		read_output(16'hffff);  // largest index
	endtask

	// register extremes and the special cases they open up
	task automatic test_register_extremes();
		// small ratio: fractional blend and gain below one
		settle();
		write_reg(REG_RATIO, 4096);
		read_output(1);
		read_output(40);        // small negative blend truncates toward zero
		// large ratio: gain of eight clips both ways
		settle();
		write_reg(REG_RATIO, 524288);
		read_output(0);
		write_sample(0, SAMPLE_MIN);
		read_output(0);
		// zero ratio collapses every position to the start and the gain to zero
		settle();
		write_reg(REG_RATIO, 0);
		read_output(1000);
		// in_length beyond the buffer counts as the buffer size
		settle();
		write_reg(REG_RATIO, 65536);
		write_reg(REG_IN_LENGTH, 2047);
		read_output(1022);
		read_output(1023);
		// in_length below two puts every valid read past the end
		settle();
		write_reg(REG_IN_LENGTH, 1);
		read_output(0);
		settle();
		write_reg(REG_IN_LENGTH, 0);
		read_output(0);
		// out_length of zero rejects every read
		settle();
		write_reg(REG_OUT_LENGTH, 0);
		read_output(0);
		settle();
		write_reg(REG_OUT_LENGTH, 65535);
		write_reg(REG_IN_LENGTH, 1024);
		read_output(65534);
		// write to an unmapped register index must leave the map untouched
		settle();
		write_reg(REG_NONE, {CFG_DATA_BITS{1'b1}});
		read_output(2);
	endtask

	// every buffer entry gets written so random reads never touch garbage
	task automatic test_buffer_fill();
		gaps_on = 1'b1;
		for (int a = 0; a < MAX_INPUT_SAMPLES; a++) begin
			write_sample(ADDR_BITS'(a), pick_sample());
		end
	endtask

	task automatic randomize_registers();
		case ($urandom_range(0, 9))
			0: write_reg(REG_RATIO, 0);
			1: write_reg(REG_RATIO, 4096);
			2: write_reg(REG_RATIO, 524288);
			3: write_reg(REG_RATIO, CFG_DATA_BITS'($urandom));
			default: write_reg(REG_RATIO, CFG_DATA_BITS'($urandom_range(4096, 524288)));
		endcase
		case ($urandom_range(0, 9))
			0: write_reg(REG_IN_LENGTH, CFG_DATA_BITS'($urandom_range(0, 1)));
			1: write_reg(REG_IN_LENGTH, 1024);
			2: write_reg(REG_IN_LENGTH, CFG_DATA_BITS'($urandom_range(1025, 2047)));
			3: write_reg(REG_IN_LENGTH, CFG_DATA_BITS'($urandom));
			default: write_reg(REG_IN_LENGTH, CFG_DATA_BITS'($urandom_range(2, 1024)));
		endcase
		case ($urandom_range(0, 9))
			0: write_reg(REG_OUT_LENGTH, 0);
			1: write_reg(REG_OUT_LENGTH, 65535);
			2: write_reg(REG_OUT_LENGTH, CFG_DATA_BITS'($urandom));
			default: write_reg(REG_OUT_LENGTH, CFG_DATA_BITS'($urandom_range(1, 65535)));
		endcase
	endtask

	// mixed traffic under one random register setting
	task automatic test_random_traffic(input int n_items, input bit with_gaps);
		settle();
		randomize_registers();
		gaps_on = with_gaps;
		repeat (n_items) begin
			if ($urandom_range(0, 3) == 0) begin
				write_sample(ADDR_BITS'($urandom), pick_sample());
			end else begin
				read_output(pick_index());
			end
		end
	endtask

	// receiver holds off for a long stretch while reads keep coming, so the
	// pipeline fills and the request side stalls
	task automatic test_output_backpressure();
		settle();
		write_reg(REG_RATIO, CFG_DATA_BITS'($urandom_range(4096, 524288)));
		write_reg(REG_IN_LENGTH, 1024);
		write_reg(REG_OUT_LENGTH, 65535);
		gaps_on      = 1'b0;
		hold_request = HOLD_CYCLES;
		repeat (40) read_output(pick_index());
	endtask

	// sender goes quiet until the pipeline has emptied, then resumes
	task automatic test_drain_pause();
		gaps_on = 1'b1;
		repeat (20) read_output(pick_index());
		wait_drained();
		repeat (20) begin
			if ($urandom_range(0, 3) == 0) begin
				write_sample(ADDR_BITS'($urandom), pick_sample());
			end else begin
				read_output(pick_index());
			end
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= REG_RATIO;
		cfg_data              <= '0;
		req_ch.valid          <= 1'b0;
		req_ch.command        <= CMD_WRITE;
		req_ch.sample_address <= '0;
		req_ch.sample_value   <= '0;
		req_ch.output_index   <= '0;
		gain_ratio = RATIO_RESET;
		input_len  = IN_LENGTH_RESET;
		output_len = OUT_LENGTH_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_buffer_fill();
		for (int p = 0; p < 3; p++) begin
			test_random_traffic(20, 1'b1);
		end
		test_output_backpressure();
		test_drain_pause();
		for (int p = 0; p < 3; p++) begin
			test_random_traffic(20, p[0]);
		end

		// let the last transfers land, then allow for anything stray
		wait_drained();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("linear_interp_resampler test passed");
		end else begin
			$display("linear_interp_resampler test failed");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/lir_pkg.sv
rtl/lir_req_if.sv
rtl/lir_rsp_if.sv
rtl/lir_ram.sv
rtl/lir_front.sv
rtl/lir_datapath.sv
rtl/linear_interp_resampler.sv
tb/sv/testbench.sv
